FILE: src/pel_pkg.sv
// pel_pkg: sizes, opcodes, status codes and controller types for the
// positional insert/erase list. No dependencies.
`timescale 1ns / 1ps

package pel_pkg;

   localparam int DEPTH   = 16;
   localparam int WIDTH   = 32;

   localparam int OPC_W   = 2;
   localparam int POS_W   = 4;
   localparam int VAL_W   = 32;
   localparam int ST_W    = 2;
   localparam int CNT_OUT_W = 5;

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [OPC_W-1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_ERASE  = 2'd2,
      OP_GET    = 2'd3
   } opcode_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      RSP_EMPTY = 1'b0,
      RSP_HOLD  = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic exec;
   } dp_cmd_type;

endpackage

FILE: src/pel_if.sv
// pel_req_if / pel_rsp_if: valid/ready channels for list requests and results.
// Uses pel_pkg for field widths.
`timescale 1ns / 1ps

interface pel_req_if
   import pel_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [OPC_W-1:0] opcode;
   logic [POS_W-1:0] position;
   logic [VAL_W-1:0] value;

   modport source (output valid, opcode, position, value, input ready);
   modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface pel_rsp_if
   import pel_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [VAL_W-1:0]     read_value;
   logic [CNT_OUT_W-1:0] element_count;
   logic [ST_W-1:0]      status;

   modport source (output valid, read_value, element_count, status, input ready);
   modport sink   (input valid, read_value, element_count, status, output ready);
endinterface

FILE: src/pel_ctrl.sv
// pel_ctrl: handshake controller; tracks whether the result register holds a
// beat and issues the execute command. Depends on pel_pkg.
`timescale 1ns / 1ps

module pel_ctrl
   import pel_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RSP_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         RSP_EMPTY: begin
            if (req_valid) state_in = RSP_HOLD;
         end
         RSP_HOLD: begin
            // result leaves; stay full only if a new request replaces it
            if (rsp_ready && !req_valid) state_in = RSP_EMPTY;
         end
         default: state_in = RSP_EMPTY;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         RSP_EMPTY: begin
            req_ready = 1'b1;
         end
         RSP_HOLD: begin
            req_ready = rsp_ready;
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
      cmd.exec = req_valid && req_ready;
   end

endmodule

FILE: src/pel_datapath.sv
// pel_datapath: entry cells with neighbor shifting, element count and the
// result register. Depends on pel_pkg.
`timescale 1ns / 1ps

module pel_datapath
   import pel_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   input  logic [OPC_W-1:0]     opcode,
   input  logic [POS_W-1:0]     position,
   input  logic [VAL_W-1:0]     value,
   output logic [VAL_W-1:0]     read_value,
   output logic [CNT_OUT_W-1:0] element_count,
   output logic [ST_W-1:0]      status
);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [WIDTH-1:0] entries_in [DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;

   logic [VAL_W-1:0]     rd_ff, rd_in;
   logic [CNT_OUT_W-1:0] cnt_out_ff;
   status_type           st_ff, st_in;

   opcode_type       op;
   logic [CMP_W-1:0] pos_c, cnt_c;
   logic             full, in_range;
   logic [WIDTH-1:0] wr_val;

   assign op       = opcode_type'(opcode);
   assign pos_c    = CMP_W'(position);
   assign cnt_c    = CMP_W'(count_ff);
   assign full     = (cnt_c == CMP_W'(DEPTH));
   assign in_range = (pos_c < cnt_c);
   assign wr_val   = WIDTH'(value);

   always_comb begin
      count_in = count_ff;
      rd_in    = '0;
      st_in    = ST_OK;
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
      end
      case (op)
         OP_APPEND: begin
            if (full) begin
               st_in = ST_FULL;
            end else begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (CMP_W'(i) == cnt_c) entries_in[i] = wr_val;
               end
               count_in = count_ff + 1'b1;
            end
         end
         OP_INSERT: begin
            if (full) begin
               st_in = ST_FULL;
            end else if (!in_range) begin
               st_in = ST_RANGE;
            end else begin
               // cell i takes its lower neighbor for pos < i <= count
               for (int i = 0; i < DEPTH; i++) begin
                  if (CMP_W'(i) == pos_c) begin
                     entries_in[i] = wr_val;
                  end else if (i > 0 && CMP_W'(i) > pos_c && CMP_W'(i) <= cnt_c) begin
                     entries_in[i] = entries_ff[(i > 0) ? i - 1 : 0];
                  end
               end
               count_in = count_ff + 1'b1;
            end
         end
         OP_ERASE: begin
            if (!in_range) begin
               st_in = ST_RANGE;
            end else begin
               // cell i takes its upper neighbor for pos <= i < count-1
               for (int i = 0; i < DEPTH - 1; i++) begin
                  if (CMP_W'(i) >= pos_c && CMP_W'(i + 1) < cnt_c) begin
                     entries_in[i] = entries_ff[i + 1];
                  end
               end
               count_in = count_ff - 1'b1;
            end
         end
         OP_GET: begin
            if (!in_range) begin
               st_in = ST_RANGE;
            end else begin
               rd_in = VAL_W'(entries_ff[IDX_W'(position)]);
            end
         end
         default: begin
            st_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         for (int i = 0; i < DEPTH; i++) begin
            entries_ff[i] <= entries_in[i];
         end
         rd_ff      <= rd_in;
         cnt_out_ff <= CNT_OUT_W'(count_in);
         st_ff      <= st_in;
      end
   end

   assign read_value    = rd_ff;
   assign element_count = cnt_out_ff;
   assign status        = st_ff;

endmodule

FILE: src/positional_insert_erase_list_core.sv
// positional_insert_erase_list_core: top level of the positional list.
// Depends on pel_pkg, pel_if, pel_ctrl and pel_datapath.
//
// Usage:
//   req carries one request beat: opcode (append, insert, erase, get),
//   position and value. rsp returns exactly one beat per request with the
//   value read by a get (zero otherwise), the element count after the
//   request and a status (ok, position out of range, list full).
//   The result beat is valid on the cycle after the request is accepted.
//   Throughput is one request per cycle while the receiver takes each beat;
//   every operation is done in the update that accepts it, because each
//   entry cell loads from its neighbor in parallel.
//   A single result register sits between the channels. When the receiver
//   stalls, the held beat stays put and req_ready drops until it is taken;
//   a new request is accepted in the same cycle the held beat leaves.
//   Reset empties the list and the result register; entry contents are not
//   cleared and are only read below the element count.
`timescale 1ns / 1ps

module positional_insert_erase_list_core
   import pel_pkg::*;
(
   input logic       clock,
   input logic       reset,
   pel_req_if.sink   req,
   pel_rsp_if.source rsp
);

   dp_cmd_type cmd;

   pel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   pel_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .opcode        (req.opcode),
      .position      (req.position),
      .value         (req.value),
      .read_value    (rsp.read_value),
      .element_count (rsp.element_count),
      .status        (rsp.status)
   );

endmodule
